@@ hw/rtl/imuab_pkg.sv @@
// IMU array averaging package: widths, operation codes, sequencer states,
// divider request type. No dependencies.
package imuab_pkg;

    localparam int AXIS_COUNT         = 6;
    localparam int GYRO_FIRST_AXIS    = 3;
    localparam int DEF_SENSOR_COUNT   = 64;
    localparam int DEF_MAX_SAMPLES    = 255;
    localparam int CAL_FRAMES_RESET   = 200;

    localparam int SENSOR_W = 6;
    localparam int AXIS_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int SUM_W    = 24;
    localparam int OFF_W    = 40;
    localparam int TOTAL_W  = 24;
    localparam int DIV_W    = 40;
    localparam int DVS_W    = 24;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_READ  = 2'd1,
        OP_CAL   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_EX,
        S_DIV,
        S_OUT,
        S_FRD,
        S_FEX,
        S_FDIV
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] dividend;
        logic [DVS_W-1:0]        divisor;
    } t_div_req;

endpackage

@@ hw/rtl/imu_array_average_bias_calibration.sv @@
// IMU array averaging with gyro bias calibration: sequencer, sum and offset
// RAMs, shared divider. Depends on imuab_pkg, imuab_ram, imuab_div.
// Accumulate: read-modify-write of the sum; unknown or out-of-range items are dropped.
// Readout: sum divided by the sample count in the 40-step divider. Frame end, start
// calibration and reset add a clearing pass over SENSOR_COUNT*6 elements; finalizing
// offsets divides gyro sums. Synchronous active-low reset starts the clearing pass.
module imu_array_average_bias_calibration import imuab_pkg::*; #(
    parameter int SENSOR_COUNT          = DEF_SENSOR_COUNT,
    parameter int MAX_SAMPLES_PER_FRAME = DEF_MAX_SAMPLES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_operation,
    input  logic [SENSOR_W-1:0]        i_sensor_index,
    input  logic [AXIS_W-1:0]          i_axis_index,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_last_element,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [SENSOR_W-1:0]        o_out_sensor,
    output logic [AXIS_W-1:0]          o_out_axis,
    output logic signed [SAMPLE_W-1:0] o_corrected_value,
    output logic                       o_has_data,
    output logic                       o_is_calibrated,
    output logic                       o_frame_end,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_W-1:0]           i_cfg_data
);

    localparam int ELEMENTS = SENSOR_COUNT * AXIS_COUNT;
    localparam int ELEM_W   = $clog2(ELEMENTS);
    localparam int CNT_W    = $clog2(MAX_SAMPLES_PER_FRAME + 1);

    t_state              r_state, n_state;
    logic [ELEM_W-1:0]   r_addr, n_addr;
    logic                r_clr_off, n_clr_off;
    logic [CNT_W-1:0]    r_samples, n_samples;
    logic                r_mode, n_mode;
    logic                r_cal, n_cal;
    logic [CFG_W-1:0]    r_frames, n_frames;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [CFG_W-1:0]    r_cfg_frames;
    logic [AXIS_W-1:0]   r_ax, n_ax;
    t_op                 r_op, n_op;
    logic                r_last, n_last;
    logic [SENSOR_W-1:0] r_sens, n_sens;
    logic [AXIS_W-1:0]   r_axis, n_axis;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [SAMPLE_W-1:0] r_off16, n_off16;
    logic [SAMPLE_W-1:0] r_res, n_res;
    logic                r_has, n_has;
    logic                r_ov, n_ov;
    logic [SENSOR_W-1:0] r_o_sens, n_o_sens;
    logic [AXIS_W-1:0]   r_o_axis, n_o_axis;
    logic [SAMPLE_W-1:0] r_o_val, n_o_val;
    logic                r_o_has, n_o_has;
    logic                r_o_cal, n_o_cal;
    logic                r_o_end, n_o_end;

    logic                sum_we, off_we;
    logic [SUM_W-1:0]    sum_wd, sum_rd;
    logic [OFF_W-1:0]    off_wd, off_rd;
    t_div_req            div_req;
    logic                div_done;
    logic signed [DIV_W-1:0] div_q;
    logic                accept;
    logic [11:0]         elem_full;
    logic                in_range;
    logic [TOTAL_W-1:0]  tot_next;
    logic [CFG_W-1:0]    frm_next;

    imuab_ram #(.WIDTH(SUM_W), .DEPTH(ELEMENTS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (r_addr),
        .i_wdata (sum_wd),
        .i_raddr (r_addr),
        .o_rdata (sum_rd)
    );

    imuab_ram #(.WIDTH(OFF_W), .DEPTH(ELEMENTS)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (r_addr),
        .i_wdata (off_wd),
        .i_raddr (r_addr),
        .o_rdata (off_rd)
    );

    imuab_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    assign accept    = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign elem_full = 12'({6'd0, i_sensor_index} * 12'd6) + 12'(i_axis_index);
    assign in_range  = ({3'd0, i_sensor_index} < 9'(SENSOR_COUNT))
                       && (i_axis_index < AXIS_W'(AXIS_COUNT));
    assign tot_next  = r_total + TOTAL_W'(r_samples);
    assign frm_next  = (r_samples != '0) ? r_frames + 1'b1 : r_frames;

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_clr_off = r_clr_off;
        n_samples = r_samples;
        n_mode    = r_mode;
        n_cal     = r_cal;
        n_frames  = r_frames;
        n_total   = r_total;
        n_ax      = r_ax;
        n_op      = r_op;
        n_last    = r_last;
        n_sens    = r_sens;
        n_axis    = r_axis;
        n_sample  = r_sample;
        n_off16   = r_off16;
        n_res     = r_res;
        n_has     = r_has;
        n_ov      = r_ov && i_stall;
        n_o_sens  = r_o_sens;
        n_o_axis  = r_o_axis;
        n_o_val   = r_o_val;
        n_o_has   = r_o_has;
        n_o_cal   = r_o_cal;
        n_o_end   = r_o_end;
        sum_we    = 1'b0;
        sum_wd    = '0;
        off_we    = 1'b0;
        off_wd    = '0;
        div_req   = '0;
        case (r_state)
            S_CLR: begin
                sum_we = 1'b1;
                off_we = r_clr_off;
                if (r_addr == ELEM_W'(ELEMENTS - 1)) begin
                    n_state   = S_IDLE;
                    n_samples = '0;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_operation);
                    n_last   = i_last_element;
                    n_sens   = i_sensor_index;
                    n_axis   = i_axis_index;
                    n_sample = i_sample_value;
                    if (t_op'(i_operation) == OP_CAL) begin
                        n_mode    = 1'b1;
                        n_frames  = '0;
                        n_total   = '0;
                        n_samples = '0;
                        n_addr    = '0;
                        n_clr_off = 1'b1;
                        n_state   = S_CLR;
                    end else if ((t_op'(i_operation) == OP_ACC
                                  || t_op'(i_operation) == OP_READ) && in_range) begin
                        n_addr  = elem_full[ELEM_W-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                sum_we = 1'b1;
                if (r_op == OP_ACC) begin
                    n_state = S_IDLE;
                    if (r_samples < CNT_W'(MAX_SAMPLES_PER_FRAME)) begin
                        sum_wd = sum_rd + {{(SUM_W-SAMPLE_W){r_sample[SAMPLE_W-1]}},
                                           r_sample};
                        if (r_last) begin
                            n_samples = r_samples + 1'b1;
                        end
                    end else begin
                        sum_we = 1'b0;
                    end
                end else if (r_mode) begin
                    if (r_axis >= AXIS_W'(GYRO_FIRST_AXIS)) begin
                        off_we = 1'b1;
                        off_wd = off_rd + {{(OFF_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd};
                    end
                    n_state = S_IDLE;
                    if (r_last) begin
                        n_total   = tot_next;
                        n_frames  = frm_next;
                        n_clr_off = 1'b0;
                        n_state   = S_CLR;
                        n_addr    = '0;
                        n_ax      = '0;
                        if (frm_next >= r_cfg_frames) begin
                            if (tot_next != '0) begin
                                n_state = S_FRD;
                            end else begin
                                n_cal  = 1'b1;
                                n_mode = 1'b0;
                            end
                        end
                    end
                end else begin
                    n_off16 = off_rd[SAMPLE_W-1:0];
                    if (r_samples != '0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {{(DIV_W-SUM_W){sum_rd[SUM_W-1]}}, sum_rd};
                        div_req.divisor  = DVS_W'(r_samples);
                        n_state          = S_DIV;
                    end else begin
                        n_res   = '0;
                        n_has   = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = div_q[SAMPLE_W-1:0] - (r_cal ? r_off16 : '0);
                    n_has   = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov     = 1'b1;
                    n_o_sens = r_sens;
                    n_o_axis = r_axis;
                    n_o_val  = r_res;
                    n_o_has  = r_has;
                    n_o_cal  = r_cal;
                    n_o_end  = r_last;
                    if (r_last) begin
                        n_addr    = '0;
                        n_clr_off = 1'b0;
                        n_state   = S_CLR;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FRD: begin
                n_state = S_FEX;
            end
            S_FEX, S_FDIV: begin
                if (r_state == S_FEX && r_ax >= AXIS_W'(GYRO_FIRST_AXIS)) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = $signed(off_rd);
                    div_req.divisor  = r_total;
                    n_state          = S_FDIV;
                end else if (r_state == S_FEX || div_done) begin
                    if (r_state == S_FDIV) begin
                        off_we = 1'b1;
                        off_wd = div_q;
                    end
                    if (r_addr == ELEM_W'(ELEMENTS - 1)) begin
                        n_cal     = 1'b1;
                        n_mode    = 1'b0;
                        n_addr    = '0;
                        n_clr_off = 1'b0;
                        n_state   = S_CLR;
                    end else begin
                        n_addr  = r_addr + 1'b1;
                        n_ax    = (r_ax == AXIS_W'(AXIS_COUNT - 1)) ? '0 : r_ax + 1'b1;
                        n_state = S_FRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_addr       <= '0;
            r_clr_off    <= 1'b1;
            r_samples    <= '0;
            r_mode       <= 1'b0;
            r_cal        <= 1'b0;
            r_frames     <= '0;
            r_total      <= '0;
            r_ax         <= '0;
            r_ov         <= 1'b0;
            r_cfg_frames <= CFG_W'(CAL_FRAMES_RESET);
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_clr_off <= n_clr_off;
            r_samples <= n_samples;
            r_mode    <= n_mode;
            r_cal     <= n_cal;
            r_frames  <= n_frames;
            r_total   <= n_total;
            r_ax      <= n_ax;
            r_ov      <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_frames <= i_cfg_data;
            end
        end
        r_op     <= n_op;
        r_last   <= n_last;
        r_sens   <= n_sens;
        r_axis   <= n_axis;
        r_sample <= n_sample;
        r_off16  <= n_off16;
        r_res    <= n_res;
        r_has    <= n_has;
        r_o_sens <= n_o_sens;
        r_o_axis <= n_o_axis;
        r_o_val  <= n_o_val;
        r_o_has  <= n_o_has;
        r_o_cal  <= n_o_cal;
        r_o_end  <= n_o_end;
    end

    assign o_cfg_ready       = 1'b1;
    assign o_valid           = r_ov;
    assign o_out_sensor      = r_o_sens;
    assign o_out_axis        = r_o_axis;
    assign o_corrected_value = r_o_val;
    assign o_has_data        = r_o_has;
    assign o_is_calibrated   = r_o_cal;
    assign o_frame_end       = r_o_end;

endmodule

@@ hw/rtl/imuab_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module imuab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/imuab_div.sv @@
// Shared iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on imuab_pkg.
module imuab_div import imuab_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_req                i_req,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic             r_neg, n_neg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_neg  = r_neg;
        trial  = {r_rem, r_quo[DIV_W-1]};
        diff   = trial - {1'b0, r_dvs};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_W - 1);
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_neg  = i_req.dividend[DIV_W-1];
            n_quo  = i_req.dividend[DIV_W-1] ? DIV_W'(-i_req.dividend)
                                              : DIV_W'(i_req.dividend);
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = diff[DVS_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DVS_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_quo) : $signed(r_quo);

endmodule

@@ hw/rtl/imuab_chk.sv @@
// Port-level checker for the IMU array averaging block, bound to the top
// level. Depends on imuab_pkg and imu_array_average_bias_calibration.
module imuab_chk import imuab_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [AXIS_W-1:0]          o_out_axis,
    input logic signed [SAMPLE_W-1:0] o_corrected_value,
    input logic                       o_has_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall && !o_valid)
        else $error("reset must start the clearing pass with no result");

    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_data |-> o_corrected_value == '0)
        else $error("empty frame result must be zero");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out_axis < AXIS_W'(AXIS_COUNT))
        else $error("result axis out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_corrected_value))
        else $error("stalled transfer changed");

endmodule

bind imu_array_average_bias_calibration imuab_chk u_imuab_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_out_axis        (o_out_axis),
    .o_corrected_value (o_corrected_value),
    .o_has_data        (o_has_data)
);

@@ tb/imu_array_average_bias_calibration_tb.sv @@
// Self-checking testbench for imu_array_average_bias_calibration: drives frames of
// sample sets and readouts, predicts averages, offsets and calibration in-line.
// Depends on imuab_pkg and the block's RTL.
module imu_array_average_bias_calibration_tb;
    import imuab_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEMS       = DEF_SENSOR_COUNT * AXIS_COUNT;
    localparam int SETTLE      = 10000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_GOAL   = 1450;

    typedef struct {
        logic [SENSOR_W-1:0]        sensor;
        logic [AXIS_W-1:0]          axis;
        logic signed [SAMPLE_W-1:0] value;
        logic                       has_data;
        logic                       calibrated;
        logic                       frame_end;
    } t_avg_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [1:0]                 i_operation = OP_ACC;
    logic [SENSOR_W-1:0]        i_sensor_index = '0;
    logic [AXIS_W-1:0]          i_axis_index = '0;
    logic signed [SAMPLE_W-1:0] i_sample_value = '0;
    logic                       i_last_element = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [SENSOR_W-1:0]        o_out_sensor;
    logic [AXIS_W-1:0]          o_out_axis;
    logic signed [SAMPLE_W-1:0] o_corrected_value;
    logic                       o_has_data;
    logic                       o_is_calibrated;
    logic                       o_frame_end;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_W-1:0]           i_cfg_data = '0;

    imu_array_average_bias_calibration uut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [SUM_W-1:0]   sum_mem [ELEMS];
    logic [OFF_W-1:0]   offset_mem [ELEMS];
    int unsigned        set_count;
    logic               calibrating;
    logic               calibrated;
    int unsigned        cal_frames_done;
    logic [TOTAL_W-1:0] cal_total;
    logic [CFG_W-1:0]   cal_frames_cfg;

    t_avg_result avg_queue[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          hold_cycles = 0;
    bit          quiet = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
        error_count++;
    endtask

    function automatic void clear_sums();
        foreach (sum_mem[e]) sum_mem[e] = '0;
        set_count = 0;
    endfunction

    function automatic void close_cal_frame();
        longint q;
        if (set_count > 0) begin
            cal_total = cal_total + TOTAL_W'(set_count);
            cal_frames_done++;
        end
        if (cal_frames_done >= cal_frames_cfg) begin
            if (cal_total != 0) begin
                foreach (offset_mem[e]) begin
                    if ((e % AXIS_COUNT) >= GYRO_FIRST_AXIS) begin
                        q = longint'($signed(offset_mem[e])) / longint'({40'd0, cal_total});
                        offset_mem[e] = q[OFF_W-1:0];
                    end
                end
            end
            calibrated = 1'b1;
            calibrating = 1'b0;
        end
    endfunction

    function automatic void predict_avg(input logic [1:0] op, input int sensor, input int axis,
                                        input logic signed [15:0] sample, input logic last);
        int          e;
        longint      v;
        t_avg_result r;
        if (op == OP_CAL) begin
            calibrating = 1'b1;
            cal_frames_done = 0;
            cal_total = '0;
            foreach (offset_mem[i]) offset_mem[i] = '0;
            clear_sums();
            return;
        end
        if (op == OP_NONE || sensor >= DEF_SENSOR_COUNT || axis >= AXIS_COUNT) return;
        e = sensor * AXIS_COUNT + axis;
        if (op == OP_ACC) begin
            if (set_count >= DEF_MAX_SAMPLES) return;
            sum_mem[e] = sum_mem[e] + {{8{sample[15]}}, sample};
            if (last) set_count++;
            return;
        end
        if (calibrating) begin
            if (axis >= GYRO_FIRST_AXIS)
                offset_mem[e] = offset_mem[e] + {{16{sum_mem[e][SUM_W-1]}}, sum_mem[e]};
            sum_mem[e] = '0;
            if (last) begin
                close_cal_frame();
                clear_sums();
            end
            return;
        end
        r.sensor = sensor[SENSOR_W-1:0];
        r.axis = axis[AXIS_W-1:0];
        r.value = '0;
        r.has_data = 1'b0;
        if (set_count > 0) begin
            v = longint'($signed(sum_mem[e])) / longint'(set_count);
            if (calibrated) v = v - longint'($signed(offset_mem[e]));
            r.value = v[15:0];
            r.has_data = 1'b1;
        end
        r.calibrated = calibrated;
        r.frame_end = last;
        avg_queue.push_back(r);
        sum_mem[e] = '0;
        if (last) clear_sums();
    endfunction

    task automatic send(input logic [1:0] op, input int sensor, input int axis,
                        input logic signed [15:0] sample, input logic last);
        if (!quiet && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_sensor_index <= sensor[SENSOR_W-1:0];
        i_axis_index <= axis[AXIS_W-1:0];
        i_sample_value <= sample;
        i_last_element <= last;
        do @(posedge i_clk); while (o_stall);
        predict_avg(op, sensor, axis, sample, last);
        items_sent++;
    endtask

    task automatic stop_sending();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        stop_sending();
        wait (avg_queue.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_cal_frames(input logic [CFG_W-1:0] frames);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= frames;
        do @(posedge i_clk); while (!o_cfg_ready);
        cal_frames_cfg = frames;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one frame: nsets sample sets over nel elements, then a readout of each
    task automatic run_frame(input int nsets, input int nel, input int noise_pct);
        int sens[$];
        int axs[$];
        int s;
        int k;
        for (k = 0; k < nel; k++) begin
            sens.push_back($urandom_range(63));
            axs.push_back($urandom_range(5));
        end
        for (s = 0; s < nsets; s++) begin
            for (k = 0; k < nel; k++) begin
                if ($urandom_range(99) < noise_pct)
                    send(($urandom_range(1) ? OP_NONE : OP_ACC), $urandom_range(63),
                         $urandom_range(6, 7), SAMPLE_W'($urandom),
                         1'($urandom_range(1)));
                send(OP_ACC, sens[k], axs[k], SAMPLE_W'($urandom), k == nel - 1);
            end
        end
        for (k = 0; k < nel; k++)
            send(OP_READ, sens[k], axs[k], SAMPLE_W'($urandom), k == nel - 1);
    endtask

    task automatic test_directed();
        send(OP_READ, 0, 0, 0, 1'b0);
        send(OP_ACC, 63, 5, 16'sh7fff, 1'b0);
        send(OP_ACC, 0, 0, -16'sh8000, 1'b0);
        send(OP_ACC, 63, 5, 16'sh7fff, 1'b0);
        send(OP_ACC, 0, 0, -16'sh8000, 1'b1);
        send(OP_NONE, 1, 1, 16'sh1234, 1'b1);
        send(OP_ACC, 2, 6, 16'sh0100, 1'b1);
        send(OP_READ, 3, 7, 16'sh0000, 1'b1);
        send(OP_ACC, 0, 0, 16'sh0003, 1'b0);
        send(OP_ACC, 63, 5, 16'sh0001, 1'b1);
        send(OP_READ, 63, 5, 16'shffff, 1'b0);
        send(OP_READ, 0, 0, 16'sh5555, 1'b0);
        send(OP_READ, 42, 2, 16'sh0000, 1'b1);
        send(OP_READ, 42, 2, 16'sh0000, 1'b1);
    endtask

    task automatic test_frame_full();
        int k;
        for (k = 0; k < DEF_MAX_SAMPLES + 2; k++)
            send(OP_ACC, 1, 1, SAMPLE_W'($urandom), 1'b1);
        send(OP_READ, 1, 1, 0, 1'b1);
    endtask

    task automatic test_calibration(input logic [CFG_W-1:0] frames, input int nframes);
        int f;
        write_cal_frames(frames);
        send(OP_CAL, $urandom_range(63), $urandom_range(7), SAMPLE_W'($urandom),
             1'($urandom_range(1)));
        send(OP_READ, 5, 4, 0, 1'b1);
        for (f = 0; f < nframes; f++)
            run_frame($urandom_range(1, 3), $urandom_range(2, 5), 0);
        stop_sending();
    endtask

    task automatic test_normal_after_cal();
        int f;
        for (f = 0; f < 4; f++)
            run_frame($urandom_range(1, 4), $urandom_range(2, 6), 5);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        run_frame(2, 8, 0);
        stop_sending();
        wait (avg_queue.size() == 0);
        run_frame(1, 4, 0);
    endtask

    task automatic test_random();
        quiet = 1'b1;
        run_frame(3, 6, 10);
        run_frame(2, 6, 10);
        quiet = 1'b0;
        while (items_sent < ITEM_GOAL) begin
            if ($urandom_range(99) < 3)
                send(OP_CAL, $urandom_range(63), $urandom_range(7), SAMPLE_W'($urandom),
                     1'b0);
            run_frame($urandom_range(1, 5), $urandom_range(1, 8), 10);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (avg_queue.size() == 0) begin
                report("unexpected transfer", o_out_sensor, -1);
            end else begin
                want = avg_queue.pop_front();
                if (o_out_sensor != want.sensor) report("out_sensor", o_out_sensor, want.sensor);
                if (o_out_axis != want.axis) report("out_axis", o_out_axis, want.axis);
                if (o_corrected_value != want.value)
                    report("corrected_value", o_corrected_value, want.value);
                if (o_has_data != want.has_data) report("has_data", o_has_data, want.has_data);
                if (o_is_calibrated != want.calibrated)
                    report("is_calibrated", o_is_calibrated, want.calibrated);
                if (o_frame_end != want.frame_end)
                    report("frame_end", o_frame_end, want.frame_end);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        foreach (offset_mem[e]) offset_mem[e] = '0;
        clear_sums();
        calibrating = 1'b0;
        calibrated = 1'b0;
        cal_frames_done = 0;
        cal_total = '0;
        cal_frames_cfg = CAL_FRAMES_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_frame_full();
        test_calibration(16'd1, 1);
        test_normal_after_cal();
        test_calibration(16'd3, 4);
        test_normal_after_cal();
        test_calibration(16'd65535, 2);
        write_cal_frames(16'd2);
        run_frame(2, 4, 0);
        test_normal_after_cal();
        test_backpressure();
        test_random();
        drain();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
